// ===== hw/rtl/sidm_pkg.sv =====
// sidm_pkg: shared widths, operation and status codes, controller/datapath structs
// depends on nothing; used by the interfaces, the controller, the datapath and the top level
`default_nettype none

package sidm_pkg;

  localparam int MAX_SEGMENTS_DEF = 256;
  localparam int SEG_WORDS_DEF    = 1024;

  localparam int OP_W   = 2;
  localparam int ID_W   = 8;
  localparam int OFF_W  = 10;
  localparam int LEN_W  = 11;
  localparam int WORD_W = 32;
  localparam int ST_W   = 3;
  // wide enough to compare against any SEG_WORDS or MAX_SEGMENTS in range
  localparam int CMP_W  = 21;

  typedef enum logic [OP_W-1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_LOAD  = 2'd2,
    OP_STORE = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_NO_ID    = 3'd1,
    ST_UNMAPPED = 3'd2,
    ST_OFFSET   = 3'd3,
    ST_LENGTH   = 3'd4
  } status_e;

  typedef struct packed {
    logic             mapped;
    logic [LEN_W-1:0] len;
  } seg_entry_t;

  typedef struct packed {
    logic capture;
    logic decide;
    logic zero;
    logic emit;
  } sidm_cmd_t;

  typedef struct packed {
    logic need_zero;
    logic zero_last;
    logic out_free;
  } sidm_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sidm_ifs.sv =====
// sidm_in_if / sidm_out_if: valid/ready channels for requests and results
// depends on sidm_pkg for field widths
`default_nettype none

interface sidm_in_if;
  logic                          valid;
  logic                          ready;
  logic [sidm_pkg::OP_W-1:0]     operation;
  logic [sidm_pkg::ID_W-1:0]     seg_id;
  logic [sidm_pkg::OFF_W-1:0]    word_offset;
  logic [sidm_pkg::WORD_W-1:0]   store_value;
  logic [sidm_pkg::LEN_W-1:0]    seg_length;

  modport source (output valid, operation, seg_id, word_offset, store_value, seg_length,
                  input ready);
  modport sink   (input valid, operation, seg_id, word_offset, store_value, seg_length,
                  output ready);
endinterface

interface sidm_out_if;
  logic                          valid;
  logic                          ready;
  logic [sidm_pkg::WORD_W-1:0]   read_word;
  logic [sidm_pkg::ID_W-1:0]     given_id;
  logic [sidm_pkg::ST_W-1:0]     status;

  modport source (output valid, read_word, given_id, status, input ready);
  modport sink   (input valid, read_word, given_id, status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/sidm_ctrl.sv =====
// sidm_ctrl: sequencing state machine for one transaction at a time
// depends on sidm_pkg (command and status structs)
`default_nettype none

module sidm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sidm_pkg::sidm_stat_t stat,
  output sidm_pkg::sidm_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LOOK   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_ZERO   = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_LOOK;
      S_LOOK:   state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = stat.need_zero ? S_ZERO : S_RESP;
      S_ZERO:   if (stat.zero_last) state_nxt = S_RESP;
      S_RESP:   if (stat.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign cmd.capture  = (state_r == S_IDLE) && in_valid;
  assign cmd.decide   = (state_r == S_DECIDE);
  assign cmd.zero     = (state_r == S_ZERO);
  assign cmd.emit     = (state_r == S_RESP) && stat.out_free;

endmodule

`default_nettype wire

// ===== hw/rtl/sidm_dp.sv =====
// sidm_dp: request registers, id allocator, segment table, freed-id stack, word memory
// and result register; depends on sidm_pkg, driven by sidm_ctrl commands
`default_nettype none

module sidm_dp #(
  parameter int MAX_SEGMENTS = sidm_pkg::MAX_SEGMENTS_DEF,
  parameter int SEG_WORDS    = sidm_pkg::SEG_WORDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sidm_pkg::sidm_cmd_t           cmd,
  output sidm_pkg::sidm_stat_t               stat,
  input  wire logic [sidm_pkg::OP_W-1:0]     in_operation,
  input  wire logic [sidm_pkg::ID_W-1:0]     in_seg_id,
  input  wire logic [sidm_pkg::OFF_W-1:0]    in_word_offset,
  input  wire logic [sidm_pkg::WORD_W-1:0]   in_store_value,
  input  wire logic [sidm_pkg::LEN_W-1:0]    in_seg_length,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [sidm_pkg::WORD_W-1:0]        out_read_word,
  output logic [sidm_pkg::ID_W-1:0]          out_given_id,
  output logic [sidm_pkg::ST_W-1:0]          out_status
);

  localparam int IW      = $clog2(MAX_SEGMENTS);
  localparam int CW      = $clog2(MAX_SEGMENTS + 1);
  localparam int OW      = (SEG_WORDS > 1) ? $clog2(SEG_WORDS) : 1;
  localparam int SLOT_SZ = 1 << OW;
  localparam int CMP_W   = sidm_pkg::CMP_W;
  localparam int ID_W    = sidm_pkg::ID_W;
  localparam int OFF_W   = sidm_pkg::OFF_W;
  localparam int LEN_W   = sidm_pkg::LEN_W;
  localparam int WORD_W  = sidm_pkg::WORD_W;

  // captured request
  sidm_pkg::op_e      op_r;
  logic [ID_W-1:0]    sid_r;
  logic [OFF_W-1:0]   off_r;
  logic [WORD_W-1:0]  val_r;
  logic [LEN_W-1:0]   len_r;

  // allocator state
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      fresh_r;

  // work registers
  logic [LEN_W-1:0]   zc_r;
  logic [IW-1:0]      mid_r;
  sidm_pkg::status_e  st_r;

  // memory read data
  sidm_pkg::seg_entry_t tbl_rd_r;
  logic [IW-1:0]        stk_rd_r;
  logic [WORD_W-1:0]    word_rd_r;

  // result register
  logic               out_valid_r;
  logic [WORD_W-1:0]  out_word_r;
  logic [ID_W-1:0]    out_gid_r;
  sidm_pkg::status_e  out_st_r;

  // storage
  sidm_pkg::seg_entry_t tbl_mem  [MAX_SEGMENTS];
  logic [IW-1:0]        stk_mem  [MAX_SEGMENTS];
  logic [WORD_W-1:0]    word_mem [MAX_SEGMENTS][SLOT_SZ];

  // index formation
  logic [IW+ID_W-1:0]   sid_ext;
  logic [IW-1:0]        sid_idx;
  logic [OW+OFF_W-1:0]  off_ext;
  logic [OW-1:0]        off_idx;
  logic [OW+LEN_W-1:0]  zc_ext;
  logic [OW-1:0]        zc_idx;
  logic [IW+ID_W-1:0]   gid_ext;
  logic [CW-1:0]        count_m1;

  assign sid_ext  = {{IW{1'b0}}, sid_r};
  assign sid_idx  = sid_ext[IW-1:0];
  assign off_ext  = {{OW{1'b0}}, off_r};
  assign off_idx  = off_ext[OW-1:0];
  assign zc_ext   = {{OW{1'b0}}, zc_r};
  assign zc_idx   = zc_ext[OW-1:0];
  assign gid_ext  = {{ID_W{1'b0}}, mid_r};
  assign count_m1 = count_r - CW'(1);

  // decision
  logic              len_bad, stk_nonempty, fresh_ok, is_mapped, off_ok, count_lt_max;
  logic              map_ok, unmap_ok, load_ok, store_ok;
  logic [IW-1:0]     map_id;
  sidm_pkg::status_e st_dec;

  assign len_bad      = CMP_W'(len_r) > CMP_W'(SEG_WORDS);
  assign stk_nonempty = (count_r != '0);
  assign fresh_ok     = CMP_W'(fresh_r) < CMP_W'(MAX_SEGMENTS);
  assign count_lt_max = CMP_W'(count_r) < CMP_W'(MAX_SEGMENTS);
  // an id past the never-used counter was never written in the table
  assign is_mapped    = (CMP_W'(sid_r) < CMP_W'(fresh_r)) && tbl_rd_r.mapped;
  assign off_ok       = (CMP_W'(off_r) < CMP_W'(tbl_rd_r.len)) &&
                        (CMP_W'(off_r) < CMP_W'(SEG_WORDS));
  assign map_id       = stk_nonempty ? stk_rd_r : fresh_r[IW-1:0];

  always_comb begin
    st_dec   = sidm_pkg::ST_OK;
    map_ok   = 1'b0;
    unmap_ok = 1'b0;
    load_ok  = 1'b0;
    store_ok = 1'b0;
    priority if (op_r == sidm_pkg::OP_MAP) begin
      priority if (len_bad)                  st_dec = sidm_pkg::ST_LENGTH;
      else if (stk_nonempty || fresh_ok)     map_ok = 1'b1;
      else                                   st_dec = sidm_pkg::ST_NO_ID;
    end else if (!is_mapped) begin
      st_dec = sidm_pkg::ST_UNMAPPED;
    end else if (op_r == sidm_pkg::OP_UNMAP) begin
      unmap_ok = 1'b1;
    end else if (!off_ok) begin
      st_dec = sidm_pkg::ST_OFFSET;
    end else if (op_r == sidm_pkg::OP_LOAD) begin
      load_ok = 1'b1;
    end else begin
      store_ok = 1'b1;
    end
  end

  assign stat.need_zero = map_ok && (len_r != '0);
  assign stat.zero_last = (zc_r == LEN_W'(len_r - LEN_W'(1)));
  assign stat.out_free  = !out_valid_r || out_ready;

  // request capture and work registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= sidm_pkg::op_e'(in_operation);
      sid_r <= in_seg_id;
      off_r <= in_word_offset;
      val_r <= in_store_value;
      len_r <= in_seg_length;
    end
    if (cmd.decide) begin
      mid_r <= map_id;
      st_r  <= st_dec;
      zc_r  <= '0;
    end else if (cmd.zero) begin
      zc_r  <= zc_r + LEN_W'(1);
    end
    if (cmd.emit) begin
      out_word_r <= (op_r == sidm_pkg::OP_LOAD && st_r == sidm_pkg::ST_OK) ? word_rd_r : '0;
      out_gid_r  <= (op_r == sidm_pkg::OP_MAP && st_r == sidm_pkg::ST_OK) ?
                    gid_ext[ID_W-1:0] : '0;
      out_st_r   <= st_r;
    end
  end

  // allocator and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.decide && map_ok) begin
        if (stk_nonempty) begin
          count_r <= count_m1;
        end else begin
          fresh_r <= fresh_r + CW'(1);
        end
      end else if (cmd.decide && unmap_ok && count_lt_max) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // segment table: mapped flag and length per id
  logic                 tbl_we;
  logic [IW-1:0]        tbl_wa;
  sidm_pkg::seg_entry_t tbl_wd;

  assign tbl_we = cmd.decide && (map_ok || unmap_ok);
  assign tbl_wa = map_ok ? map_id : sid_idx;
  assign tbl_wd = map_ok ? sidm_pkg::seg_entry_t'{mapped: 1'b1, len: len_r} :
                           sidm_pkg::seg_entry_t'{mapped: 1'b0, len: tbl_rd_r.len};

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    tbl_rd_r <= tbl_mem[sid_idx];
  end

  // freed-id stack, top entry read ahead
  always_ff @(posedge clk) begin
    if (cmd.decide && unmap_ok && count_lt_max) begin
      stk_mem[count_r[IW-1:0]] <= sid_idx;
    end
    stk_rd_r <= stk_mem[count_m1[IW-1:0]];
  end

  // word memory, one port
  logic              w_we, w_re;
  logic [IW-1:0]     w_id;
  logic [OW-1:0]     w_off;
  logic [WORD_W-1:0] w_wd;

  assign w_we  = (cmd.decide && store_ok) || cmd.zero;
  assign w_re  = cmd.decide && load_ok;
  assign w_id  = cmd.zero ? mid_r : sid_idx;
  assign w_off = cmd.zero ? zc_idx : off_idx;
  assign w_wd  = cmd.zero ? '0 : val_r;

  always_ff @(posedge clk) begin
    if (w_we) begin
      word_mem[w_id][w_off] <= w_wd;
    end
    if (w_re) begin
      word_rd_r <= word_mem[w_id][w_off];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_word = out_word_r;
  assign out_given_id  = out_gid_r;
  assign out_status    = out_st_r;

  // freed ids are always ids that were handed out before
  a_freed_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= fresh_r) else $error("freed count exceeds used ids");

  a_fresh_capped: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(fresh_r) <= CMP_W'(MAX_SEGMENTS)) else $error("fresh id beyond pool");

  a_zero_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.zero |-> (zc_r < len_r)) else $error("zeroing past segment length");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r) else $error("result not presented after emit");

endmodule

`default_nettype wire

// ===== hw/rtl/segment_id_allocator_memory.sv =====
// segment_id_allocator_memory: top level of the segmented word memory with id allocation
// depends on sidm_pkg, sidm_ifs (channels), sidm_ctrl and sidm_dp
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+-------------------------------------------------------
//   in_if    | in  | valid/ready  | operation, seg_id, word_offset, store_value, seg_length
//   out_if   | out | valid/ready  | read_word, given_id, status
//
// steps: unmap, load, store and a rejected map go through accept, table/stack read,
//   decide and result; a granted map with a nonzero seg_length adds a zero sweep before the
//   result, one zeroed word per cycle through the single word memory port
// one transaction is in flight at a time; the next one is accepted while its result
//   still sits in the output register
// reset: synchronous, active low; no clearing pass, a table entry counts only below the
//   never-used id counter, so uninitialized entries are never trusted
// stalls: a held result holds the finished transaction in its result state
`default_nettype none

module segment_id_allocator_memory #(
  parameter int MAX_SEGMENTS = sidm_pkg::MAX_SEGMENTS_DEF,
  parameter int SEG_WORDS    = sidm_pkg::SEG_WORDS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sidm_in_if.sink    in_if,
  sidm_out_if.source out_if
);

  sidm_pkg::sidm_cmd_t  cmd;
  sidm_pkg::sidm_stat_t stat;
  logic                 in_ready;

  // sequencer: accept, look up, decide, zero sweep, result
  sidm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage, allocator and result register
  sidm_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .SEG_WORDS    (SEG_WORDS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_operation   (in_if.operation),
    .in_seg_id      (in_if.seg_id),
    .in_word_offset (in_if.word_offset),
    .in_store_value (in_if.store_value),
    .in_seg_length  (in_if.seg_length),
    .out_ready      (out_if.ready),
    .out_valid      (out_if.valid),
    .out_read_word  (out_if.read_word),
    .out_given_id   (out_if.given_id),
    .out_status     (out_if.status)
  );

  assign in_if.ready = in_ready;

endmodule

`default_nettype wire
